@@ hw/rtl/qts_pkg.sv @@
// Package for the quoted token scanner: request and response structs,
// result and status codes, and the token limit. No dependencies.
package qts_pkg;

   localparam int MAX_TOKENS = 8;
   localparam int TOK_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

   localparam logic [1:0] RK_BYTE  = 2'd0;
   localparam logic [1:0] RK_CLOSE = 2'd1;
   localparam logic [1:0] RK_DONE  = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_MANY   = 2'd1;
   localparam logic [1:0] ST_UNTERM = 2'd2;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] token_byte;
      logic [2:0] token_number;
      logic [1:0] status;
      logic [3:0] token_count;
      logic       last_of_run;
   } rsp_type;

endpackage

@@ hw/rtl/quoted_token_scanner_core.sv @@
// Quoted token scanner top level: token state flags and a three-entry
// response queue. Depends on qts_pkg.
//
// Takes one request per clock while req_stall is low. Each request
// yields zero, one or two responses; only an end-of-command request that
// closes an open token yields two. Responses pass through a three-entry queue,
// and req_stall is high while fewer than two queue slots are free. A
// two-response request leaves two responses queued, so req_stall rises for
// the following cycle even with rsp_stall low; every other request keeps
// the rate at one request per cycle while rsp_stall stays low.
module quoted_token_scanner_core
   import qts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] QDEPTH = 2'd3;

   logic             in_quote_ff, in_quote_in;
   logic             empty_seen_ff, empty_seen_in;
   logic             has_bytes_ff, has_bytes_in;
   logic [TOK_W-1:0] cur_tok_ff, cur_tok_in;
   logic             overflow_ff, overflow_in;

   rsp_type          queue_ff [3];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   logic             req_acc, rsp_acc, token_open, room_next;
   logic [1:0]       n_push;
   rsp_type          res0, res1;
   logic [TOK_W:0]   tok_plus1;
   logic [TOK_W+8:0] tok_ext, plus1_ext;
   logic [2:0]       tok_num;
   logic [3:0]       tok_cnt, tok_cnt_plus1;

   function automatic logic [1:0] ptr_inc(input logic [1:0] p);
      ptr_inc = (p == QDEPTH - 2'd1) ? 2'd0 : p + 2'd1;
   endfunction

   assign req_stall = (count_ff > 2'd1);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   assign token_open    = empty_seen_ff || has_bytes_ff;
   assign tok_plus1     = {1'b0, cur_tok_ff} + {{TOK_W{1'b0}}, 1'b1};
   assign room_next     = tok_plus1 < (TOK_W + 1)'(MAX_TOKENS);
   assign tok_ext       = {{9{1'b0}}, cur_tok_ff};
   assign plus1_ext     = {{8{1'b0}}, tok_plus1};
   assign tok_num       = tok_ext[2:0];
   assign tok_cnt       = tok_ext[3:0];
   assign tok_cnt_plus1 = plus1_ext[3:0];

   always_comb begin
      in_quote_in   = in_quote_ff;
      empty_seen_in = empty_seen_ff;
      has_bytes_in  = has_bytes_ff;
      cur_tok_in    = cur_tok_ff;
      overflow_in   = overflow_ff;
      n_push        = 2'd0;
      res0          = '0;
      res1          = '0;
      if (req_acc) begin
         if (req_data.kind == KIND_END) begin
            n_push = 2'd1;
            res0.result_kind = RK_DONE;
            res0.last_of_run = 1'b1;
            if (overflow_ff) begin
               res0.status = ST_MANY;
            end else if (in_quote_ff) begin
               res0.status = ST_UNTERM;
            end else if (token_open) begin
               // close of the last token, then the count
               n_push = 2'd2;
               res0.result_kind  = RK_CLOSE;
               res0.token_number = tok_num;
               res0.last_of_run  = 1'b0;
               res1.result_kind  = RK_DONE;
               res1.token_count  = tok_cnt_plus1;
               res1.last_of_run  = 1'b1;
            end else begin
               res0.token_count = tok_cnt;
            end
            in_quote_in   = 1'b0;
            empty_seen_in = 1'b0;
            has_bytes_in  = 1'b0;
            cur_tok_in    = '0;
            overflow_in   = 1'b0;
         end else if (overflow_ff) begin
            // bytes dropped until end of command
         end else if (req_data.char_in == CH_QUOTE) begin
            if (in_quote_ff && !has_bytes_ff) begin
               empty_seen_in = 1'b1;
            end
            in_quote_in = !in_quote_ff;
         end else if (req_data.char_in == CH_SPACE && !in_quote_ff) begin
            if (token_open) begin
               if (room_next) begin
                  n_push = 2'd1;
                  res0.result_kind  = RK_CLOSE;
                  res0.token_number = tok_num;
                  res0.last_of_run  = 1'b1;
                  cur_tok_in    = tok_plus1[TOK_W-1:0];
                  empty_seen_in = 1'b0;
                  has_bytes_in  = 1'b0;
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end else begin
            n_push = 2'd1;
            res0.result_kind  = RK_BYTE;
            res0.token_byte   = req_data.char_in;
            res0.token_number = tok_num;
            res0.last_of_run  = 1'b1;
            has_bytes_in = 1'b1;
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      case (n_push)
         2'd1:    wr_ptr_in = ptr_inc(wr_ptr_ff);
         2'd2:    wr_ptr_in = ptr_inc(ptr_inc(wr_ptr_ff));
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = rsp_acc ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + n_push - {1'b0, rsp_acc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quote_ff   <= 1'b0;
         empty_seen_ff <= 1'b0;
         has_bytes_ff  <= 1'b0;
         cur_tok_ff    <= '0;
         overflow_ff   <= 1'b0;
         wr_ptr_ff     <= 2'd0;
         rd_ptr_ff     <= 2'd0;
         count_ff      <= 2'd0;
      end else begin
         in_quote_ff   <= in_quote_in;
         empty_seen_ff <= empty_seen_in;
         has_bytes_ff  <= has_bytes_in;
         cur_tok_ff    <= cur_tok_in;
         overflow_ff   <= overflow_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_push == 2'd2) begin
         queue_ff[ptr_inc(wr_ptr_ff)] <= res1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QDEPTH)
      else $error("response queue count out of range");

   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (count_ff <= QDEPTH - 2'd2))
      else $error("request accepted without room for two responses");

   a_pair_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_of_run) |-> (count_ff >= 2'd2))
      else $error("first response of a pair queued without its partner");

   a_token_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, cur_tok_ff} < (TOK_W + 1)'(MAX_TOKENS)))
      else $error("token index beyond limit");

endmodule
